// ===== hw/rtl/rcfd_pkg.sv =====
// shared types and constants for the rc receiver frame decoder
package rcfd_pkg;

   localparam int FRAME_BYTES = 18;
   localparam int FRAME_BITS  = FRAME_BYTES * 8;
   localparam int STICK_W     = 11;
   localparam int POS_W       = 5;
   localparam int ADDR_W      = 4;

   localparam logic [STICK_W-1:0] STICK_LOW_RESET    = 11'd364;
   localparam logic [STICK_W-1:0] STICK_HIGH_RESET   = 11'd1684;
   localparam logic [STICK_W-1:0] STICK_CENTER_RESET = 11'd1024;
   localparam logic [3:0]         SWITCH_DEFAULT     = 4'hF;

   // register indexes on the csr port (word address)
   localparam logic [1:0] REG_STICK_LOW    = 2'd0;
   localparam logic [1:0] REG_STICK_HIGH   = 2'd1;
   localparam logic [1:0] REG_STICK_CENTER = 2'd2;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_IDLE = 1'b1;

   typedef struct packed {
      logic [STICK_W-1:0] stick_low_limit;
      logic [STICK_W-1:0] stick_high_limit;
      logic [STICK_W-1:0] stick_center;
   } cfg_type;

   typedef struct packed {
      logic [STICK_W-1:0] right_stick_x;
      logic [STICK_W-1:0] right_stick_y;
      logic [STICK_W-1:0] left_stick_x;
      logic [STICK_W-1:0] left_stick_y;
      logic [3:0]         switches;
      logic signed [15:0] mouse_x;
      logic signed [15:0] mouse_y;
      logic signed [15:0] mouse_z;
      logic [15:0]        mouse_buttons;
      logic [15:0]        key_mask;
      logic [15:0]        channel_word;
      logic               defaulted;
   } rsp_type;

endpackage

// ===== hw/rtl/rc_receiver_frame_decoder_top.sv =====
// top level of the rc receiver frame decoder: frame store, csr block, result register
// an idle transaction shows its result on rsp_ in the cycle after acceptance
// throughput: one req transaction per cycle; ready is held low only while a result
//   is pending and rsp_ready is low, set by the single output register
// a data transaction writes the frame store in place and produces no result
// reset: synchronous, clears frame store, write position, result valid, and loads
//   the stick limits and center with their defaults
module rc_receiver_frame_decoder_top (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_kind,
   input  logic [7:0]                   req_data_byte,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [rcfd_pkg::STICK_W-1:0] rsp_right_stick_x,
   output logic [rcfd_pkg::STICK_W-1:0] rsp_right_stick_y,
   output logic [rcfd_pkg::STICK_W-1:0] rsp_left_stick_x,
   output logic [rcfd_pkg::STICK_W-1:0] rsp_left_stick_y,
   output logic [3:0]                   rsp_switches,
   output logic signed [15:0]           rsp_mouse_x,
   output logic signed [15:0]           rsp_mouse_y,
   output logic signed [15:0]           rsp_mouse_z,
   output logic [15:0]                  rsp_mouse_buttons,
   output logic [15:0]                  rsp_key_mask,
   output logic [15:0]                  rsp_channel_word,
   output logic                         rsp_defaulted,
   // csr port
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [rcfd_pkg::ADDR_W-1:0]  paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);
   import rcfd_pkg::*;

   // frame store, one byte register per slot
   logic [7:0]       store_ff [FRAME_BYTES];
   logic [POS_W-1:0] wpos_ff, wpos_in;
   logic [FRAME_BITS-1:0] frame;

   cfg_type cfg_ff;
   rsp_type dec_rsp;
   rsp_type rsp_ff;
   logic    rsp_valid_ff, rsp_valid_in;

   logic req_fire, rsp_fire, csr_write;
   logic [1:0] csr_index;

   // handshakes
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;

   // flatten the store little endian, byte 0 in the low bits
   always_comb begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
         frame[i*8 +: 8] = store_ff[i];
      end
   end

   // write position: advances per stored byte, saturates at frame length,
   // returns to zero on idle
   always_comb begin
      wpos_in = wpos_ff;
      if (req_fire) begin
         if (req_kind == KIND_IDLE) begin
            wpos_in = '0;
         end else if (wpos_ff < POS_W'(FRAME_BYTES)) begin
            wpos_in = wpos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FRAME_BYTES; i++) begin
            store_ff[i] <= '0;
         end
         wpos_ff <= '0;
      end else begin
         // bytes past the frame length are dropped
         if (req_fire && req_kind == KIND_DATA && wpos_ff < POS_W'(FRAME_BYTES)) begin
            store_ff[wpos_ff] <= req_data_byte;
         end
         wpos_ff <= wpos_in;
      end
   end

   // decode straight from the store; stale bytes of a short frame are kept
   rcfd_decode u_decode (
      .frame (frame),
      .cfg   (cfg_ff),
      .rsp   (dec_rsp)
   );

   // result register, loaded on an accepted idle transaction
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire && req_kind == KIND_IDLE) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_fire && req_kind == KIND_IDLE) begin
         rsp_ff <= dec_rsp;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_right_stick_x = rsp_ff.right_stick_x;
   assign rsp_right_stick_y = rsp_ff.right_stick_y;
   assign rsp_left_stick_x  = rsp_ff.left_stick_x;
   assign rsp_left_stick_y  = rsp_ff.left_stick_y;
   assign rsp_switches      = rsp_ff.switches;
   assign rsp_mouse_x       = rsp_ff.mouse_x;
   assign rsp_mouse_y       = rsp_ff.mouse_y;
   assign rsp_mouse_z       = rsp_ff.mouse_z;
   assign rsp_mouse_buttons = rsp_ff.mouse_buttons;
   assign rsp_key_mask      = rsp_ff.key_mask;
   assign rsp_channel_word  = rsp_ff.channel_word;
   assign rsp_defaulted     = rsp_ff.defaulted;

   // csr block: word addressed, no wait states, unused index ignored
   assign pready    = 1'b1;
   assign csr_index = paddr[ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stick_low_limit  <= STICK_LOW_RESET;
         cfg_ff.stick_high_limit <= STICK_HIGH_RESET;
         cfg_ff.stick_center     <= STICK_CENTER_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_STICK_LOW:    cfg_ff.stick_low_limit  <= pwdata[STICK_W-1:0];
            REG_STICK_HIGH:   cfg_ff.stick_high_limit <= pwdata[STICK_W-1:0];
            REG_STICK_CENTER: cfg_ff.stick_center     <= pwdata[STICK_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_STICK_LOW:    prdata = {21'd0, cfg_ff.stick_low_limit};
         REG_STICK_HIGH:   prdata = {21'd0, cfg_ff.stick_high_limit};
         REG_STICK_CENTER: prdata = {21'd0, cfg_ff.stick_center};
         default:          prdata = '0;
      endcase
   end

endmodule

// ===== hw/rtl/rcfd_decode.sv =====
// frame unpacking, range check and default substitution
module rcfd_decode (
   input  logic [rcfd_pkg::FRAME_BITS-1:0] frame,
   input  rcfd_pkg::cfg_type               cfg,
   output rcfd_pkg::rsp_type               rsp
);
   import rcfd_pkg::*;

   logic [STICK_W-1:0] rx, ry, lx, ly;
   logic [1:0]         rs, ls;
   logic               bad;

   function automatic logic stick_ok(logic [STICK_W-1:0] v, cfg_type c);
      return (v >= c.stick_low_limit) && (v <= c.stick_high_limit);
   endfunction

   assign rx = frame[10:0];
   assign ry = frame[21:11];
   assign lx = frame[32:22];
   assign ly = frame[43:33];
   assign rs = frame[45:44];
   assign ls = frame[47:46];

   assign bad = !stick_ok(rx, cfg) || !stick_ok(ry, cfg) || !stick_ok(lx, cfg)
                || !stick_ok(ly, cfg) || (rs == 2'd0) || (ls == 2'd0);

   always_comb begin
      if (bad) begin
         rsp               = '0;
         rsp.right_stick_x = cfg.stick_center;
         rsp.right_stick_y = cfg.stick_center;
         rsp.left_stick_x  = cfg.stick_center;
         rsp.left_stick_y  = cfg.stick_center;
         rsp.switches      = SWITCH_DEFAULT;
         rsp.defaulted     = 1'b1;
      end else begin
         rsp.right_stick_x = rx;
         rsp.right_stick_y = ry;
         rsp.left_stick_x  = lx;
         rsp.left_stick_y  = ly;
         rsp.switches      = {ls, rs};
         rsp.mouse_x       = frame[63:48];
         rsp.mouse_y       = frame[79:64];
         rsp.mouse_z       = frame[95:80];
         rsp.mouse_buttons = frame[111:96];
         rsp.key_mask      = frame[127:112];
         rsp.channel_word  = frame[143:128];
         rsp.defaulted     = 1'b0;
      end
   end

endmodule

// ===== hw/rtl/rcfd_checker.sv =====
// port level checks for the rc receiver frame decoder, bound to the top level
module rcfd_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_kind,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [3:0]                   rsp_switches,
   input logic signed [15:0]           rsp_mouse_x,
   input logic [15:0]                  rsp_key_mask,
   input logic [15:0]                  rsp_channel_word,
   input logic                         rsp_defaulted,
   input logic                         pready
);
   import rcfd_pkg::*;

   // a pending result is held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a data transaction with no pending result leaves the result channel empty
   a_data_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == KIND_DATA && !rsp_valid |=> !rsp_valid)
      else $error("data transaction produced a result");

   // an idle transaction always produces a result next cycle
   a_idle_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == KIND_IDLE |=> rsp_valid)
      else $error("idle transaction gave no result");

   // defaulted frames report the fixed switch value and zero mouse_x, key_mask and channel_word
   a_default_vals: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_defaulted |-> rsp_switches == SWITCH_DEFAULT && rsp_mouse_x == 16'sd0
         && rsp_key_mask == 16'd0 && rsp_channel_word == 16'd0)
      else $error("defaulted result carries payload");

   // accepted frames never carry a zero switch
   a_switch_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_defaulted |-> rsp_switches[1:0] != 2'd0 && rsp_switches[3:2] != 2'd0
         && pready)
      else $error("accepted frame with zero switch");

endmodule

bind rc_receiver_frame_decoder_top rcfd_checker u_rcfd_checker (.*);
